// ===== rtl/segmented_prime_sieve_macros.svh =====
// ----------------------------------------------------------------------------
// segmented prime sieve assertion macros
// shared property wrappers for the sieve's checks
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_PRIME_SIEVE_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// invariant checked on every clock edge outside reset
`define SPS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// types and constants of the segmented prime sieve
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int SEGMENT_SIZE_DEF      = 65536;
    localparam int PRIME_STORE_DEPTH_DEF = 8192;

    localparam logic        OP_RESTART      = 1'b0;
    localparam logic        OP_NEXT         = 1'b1;
    localparam logic [32:0] SMALL_PRIME_MAX = 33'd65535;
    localparam logic [32:0] FIRST_CANDIDATE = 33'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] limit;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] prime;
    } rsp_t;

endpackage

// ===== rtl/segmented_prime_sieve.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_sieve
// incremental segmented sieve of eratosthenes over 32-bit values
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// req      in         req_valid/stall    req_t  (op, limit)
// rsp      out        rsp_valid/stall    rsp_t  (found, prime)
//
// each scanned candidate passes a map read and a test; marking writes one multiple per
// cycle; a segment change clears the map, then per stored prime reads and squares it,
// runs a serial divider when the base is past its square, and writes its marks
// after reset and after each restart a clear pass over the map runs, req_stall high
// a result waits in the output register while rsp_stall is high; the next transaction
// is taken meanwhile
// ----------------------------------------------------------------------------
`include "segmented_prime_sieve_macros.svh"

module segmented_prime_sieve
    import sps_pkg::*;
#(
    parameter int SEGMENT_SIZE      = SEGMENT_SIZE_DEF,
    parameter int PRIME_STORE_DEPTH = PRIME_STORE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int MAP_AW = $clog2(SEGMENT_SIZE);
    localparam int PRM_AW = $clog2(PRIME_STORE_DEPTH);
    localparam int CNT_W  = $clog2(PRIME_STORE_DEPTH + 1);
    localparam logic [32:0]       SEG33     = 33'(SEGMENT_SIZE);
    localparam logic [31:0]       SEG32     = 32'(SEGMENT_SIZE);
    localparam logic [MAP_AW-1:0] MAP_LAST  = MAP_AW'(SEGMENT_SIZE - 1);
    localparam logic [CNT_W-1:0]  STORE_MAX = CNT_W'(PRIME_STORE_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_SQ       = 4'd4;
    localparam logic [3:0] S_MARK     = 4'd5;
    localparam logic [3:0] S_DONE     = 4'd6;
    localparam logic [3:0] S_ADV_RD   = 4'd7;
    localparam logic [3:0] S_ADV_WAIT = 4'd8;
    localparam logic [3:0] S_ADV_SQ   = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_ADV_NEXT = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        after_reg, after_next;
    logic [MAP_AW-1:0] clr_reg, clr_next;
    logic [31:0]       base_reg, base_next;
    logic [32:0]       cand_reg, cand_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [31:0]       limit_reg, limit_next;
    logic [15:0]       p_reg, p_next;
    logic [31:0]       sq_reg, sq_next;
    logic [32:0]       midx_reg, midx_next;
    logic [31:0]       dq_reg, dq_next;
    logic [16:0]       rem_reg, rem_next;
    logic [4:0]        dcnt_reg, dcnt_next;
    rsp_t              res_reg, res_next;
    logic              ovalid_reg, ovalid_next;
    rsp_t              out_reg, out_next;

    logic              map_we, map_wdata, map_rdata;
    logic [MAP_AW-1:0] map_addr;
    logic              prm_we;
    logic [PRM_AW-1:0] prm_addr;
    logic [15:0]       prm_rdata;

    logic [32:0] seg_end;
    logic [15:0] mul_a;
    logic [31:0] mul_p;
    logic [16:0] div_t, div_r;

    assign seg_end = {1'b0, base_reg} + SEG33;
    assign mul_a   = (state_reg == S_READ) ? cand_reg[15:0] : prm_rdata;
    assign mul_p   = 32'(mul_a) * 32'(mul_a);
    assign div_t   = {rem_reg[15:0], dq_reg[31]};
    assign div_r   = (div_t >= {1'b0, p_reg}) ? div_t - {1'b0, p_reg} : div_t;

    sps_ram #(.WIDTH(1), .DEPTH(SEGMENT_SIZE)) u_map (
        .clk   (clk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    sps_ram #(.WIDTH(16), .DEPTH(PRIME_STORE_DEPTH)) u_primes (
        .clk   (clk),
        .we    (prm_we),
        .addr  (prm_addr),
        .wdata (cand_reg[15:0]),
        .rdata (prm_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = ovalid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        map_we    = 1'b0;
        map_wdata = 1'b0;
        map_addr  = clr_reg;
        prm_we    = 1'b0;
        prm_addr  = count_reg[PRM_AW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
            end
            S_SCAN:
            begin
                map_addr = MAP_AW'(cand_reg - {1'b0, base_reg});
            end
            S_MARK:
            begin
                map_addr  = midx_reg[MAP_AW-1:0];
                map_wdata = 1'b1;
                map_we    = (midx_reg < SEG33);
            end
            S_READ:
            begin
                prm_we = !map_rdata && (cand_reg <= SMALL_PRIME_MAX)
                         && (count_reg < STORE_MAX);
            end
            S_ADV_RD:
            begin
                prm_addr = k_reg[PRM_AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        clr_next    = clr_reg;
        base_next   = base_reg;
        cand_next   = cand_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        limit_next  = limit_reg;
        p_next      = p_reg;
        sq_next     = sq_reg;
        midx_next   = midx_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && rsp_stall;
        out_next    = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    limit_next = req.limit;
                    res_next   = '0;
                    if (req.op == OP_RESTART)
                    begin
                        base_next  = '0;
                        cand_next  = FIRST_CANDIDATE;
                        count_next = '0;
                        clr_next   = '0;
                        after_next = S_DONE;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MAP_LAST)
                begin
                    clr_next   = '0;
                    state_next = after_reg;
                end
            end
            S_SCAN:
            begin
                if (cand_reg > {1'b0, limit_reg})
                begin
                    state_next = S_DONE;
                end
                else if (cand_reg >= seg_end)
                begin
                    base_next  = base_reg + SEG32;
                    k_next     = '0;
                    after_next = S_ADV_RD;
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cand_next = cand_reg + 1'b1;
                if (map_rdata)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    res_next.found = 1'b1;
                    res_next.prime = cand_reg[31:0];
                    if (cand_reg <= SMALL_PRIME_MAX)
                    begin
                        p_next     = cand_reg[15:0];
                        sq_next    = mul_p;
                        state_next = S_SQ;
                        if (count_reg < STORE_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SQ:
            begin
                if (sq_reg >= base_reg)
                begin
                    midx_next  = {1'b0, sq_reg - base_reg};
                    after_next = S_DONE;
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                if (midx_reg < SEG33)
                begin
                    midx_next = midx_reg + 33'(p_reg);
                end
                else
                begin
                    state_next = after_reg;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || !rsp_stall)
                begin
                    ovalid_next = 1'b1;
                    out_next    = res_reg;
                    state_next  = S_IDLE;
                end
            end
            S_ADV_RD:
            begin
                state_next = (k_reg < count_reg) ? S_ADV_WAIT : S_SCAN;
            end
            S_ADV_WAIT:
            begin
                p_next     = prm_rdata;
                sq_next    = mul_p;
                state_next = S_ADV_SQ;
            end
            S_ADV_SQ:
            begin
                if ({1'b0, sq_reg} > seg_end)
                begin
                    state_next = S_SCAN;
                end
                else if (p_reg < 16'd2)
                begin
                    state_next = S_ADV_NEXT;
                end
                else if (sq_reg >= base_reg)
                begin
                    midx_next  = {1'b0, sq_reg - base_reg};
                    after_next = S_ADV_NEXT;
                    state_next = S_MARK;
                end
                else
                begin
                    dq_next    = base_reg;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_r;
                dq_next   = {dq_reg[30:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd31)
                begin
                    midx_next  = (div_r == '0) ? '0 : 33'({1'b0, p_reg} - div_r);
                    after_next = S_ADV_NEXT;
                    state_next = S_MARK;
                end
            end
            S_ADV_NEXT:
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_ADV_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            after_reg  <= S_IDLE;
            clr_reg    <= '0;
            base_reg   <= '0;
            cand_reg   <= FIRST_CANDIDATE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            after_reg  <= after_next;
            clr_reg    <= clr_next;
            base_reg   <= base_next;
            cand_reg   <= cand_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        limit_reg <= limit_next;
        p_reg     <= p_next;
        sq_reg    <= sq_next;
        midx_reg  <= midx_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    `SPS_ASSERT_ALWAYS(a_cand_min, cand_reg >= FIRST_CANDIDATE, "candidate below two")
    `SPS_ASSERT_ALWAYS(a_count_max, count_reg <= STORE_MAX, "prime store count overflow")
    `SPS_ASSERT_IMP(a_found_prime, rsp_valid && rsp.found, rsp.prime >= 32'd2,
        "found value below two")
    `SPS_ASSERT_IMP(a_found_below_cand, rsp_valid && rsp.found && state_reg == S_IDLE,
        {1'b0, rsp.prime} < cand_reg, "candidate did not pass reported prime")

endmodule

// ===== rtl/sps_ram.sv =====
// ----------------------------------------------------------------------------
// sps_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
